@@ hdl/crc16_framed_packet_receiver_macros.svh @@
// assertion macros for the framed packet receiver
// expects clk and arst_n in the scope where a macro is used
`ifndef CRC16_FRAMED_PACKET_RECEIVER_MACROS_SVH
`define CRC16_FRAMED_PACKET_RECEIVER_MACROS_SVH

// property checked on every rising edge outside reset
`define CFPR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define CFPR_NEVER(label, cond, msg) \
	`CFPR_ASSERT(label, !(cond), msg)

`endif

@@ hdl/cfpr_pkg.sv @@
// shared types, constants and the bytewise crc step of the framed packet receiver
// no dependencies
`timescale 1ns / 1ps

package cfpr_pkg;

	localparam int BYTE_W      = 8;
	localparam int LEN_W       = 16;
	localparam int CRC_W       = 16;
	localparam int TICK_W      = 8;
	localparam int KIND_W      = 3;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int OUT_DATA_W  = BYTE_W + LEN_W;

	localparam logic [CRC_W-1:0]  CRC_POLY            = 16'h1021;
	localparam logic [LEN_W-1:0]  DEFAULT_MAX_PAYLOAD = 16'd4096;
	localparam logic [TICK_W-1:0] DEFAULT_TIMEOUT     = 8'd50;

	localparam logic [BYTE_W-1:0] START_SHORT = 8'd2;
	localparam logic [BYTE_W-1:0] START_LONG  = 8'd3;
	localparam logic [BYTE_W-1:0] STOP_BYTE   = 8'd3;

	localparam logic [CFG_INDEX_W-1:0] REG_MAX_PAYLOAD   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_TICKS = 2'd1;

	typedef enum logic [2:0] {
		ST_IDLE    = 3'd0,
		ST_LEN_HI  = 3'd1,
		ST_LEN_LO  = 3'd2,
		ST_PAYLOAD = 3'd3,
		ST_CRC_HI  = 3'd4,
		ST_CRC_LO  = 3'd5,
		ST_STOP    = 3'd6
	} frame_state_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_BYTE     = 3'd0,
		KIND_GOOD     = 3'd1,
		KIND_CRC_BAD  = 3'd2,
		KIND_STOP_BAD = 3'd3,
		KIND_TIMEOUT  = 3'd4
	} result_kind_t;

	typedef struct packed {
		logic              valid;
		result_kind_t      kind;
		logic [BYTE_W-1:0] data;
		logic [LEN_W-1:0]  length;
	} cfpr_result_t;

	function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc,
		input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] c;
		c = crc ^ {b, {(CRC_W-BYTE_W){1'b0}}};
		for (int i = 0; i < BYTE_W; i++) begin
			c = c[CRC_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

@@ hdl/crc16_framed_packet_receiver.sv @@
// an accepted item goes into the input register; its result is registered in the result register and shown on m_*
// throughput: one item per cycle; s_tready drops only while the input register holds
// an item and a result waits on m_* with m_tready low
// reset: arst_n clears the frame state, counters and crc; max_payload returns to 4096,
// timeout_ticks to 50; cfg_ready is always high
// top level of the framed packet receiver; depends on cfpr_pkg, cfpr_frame_fsm and the macros
`timescale 1ns / 1ps
`include "crc16_framed_packet_receiver_macros.svh"

module crc16_framed_packet_receiver (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [cfpr_pkg::BYTE_W-1:0]      s_tdata,   // byte_value
	input  logic                             s_tuser,   // cmd
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [cfpr_pkg::OUT_DATA_W-1:0]  m_tdata,   // out_byte, frame_length
	output logic [cfpr_pkg::KIND_W-1:0]      m_tuser,   // result_kind
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [cfpr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [cfpr_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import cfpr_pkg::*;

	logic [LEN_W-1:0]  max_payload_q;
	logic [TICK_W-1:0] timeout_ticks_q;

	logic              in_valid_s1;
	logic              cmd_s1;
	logic [BYTE_W-1:0] byte_s1;

	logic              out_valid_s2;
	result_kind_t      kind_s2;
	logic [BYTE_W-1:0] out_byte_s2;
	logic [LEN_W-1:0]  frame_length_s2;

	logic         advance;
	cfpr_result_t result;

	assign advance   = !out_valid_s2 || m_tready;
	assign s_tready  = !in_valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q   <= DEFAULT_MAX_PAYLOAD;
			timeout_ticks_q <= DEFAULT_TIMEOUT;
		end else if (cfg_valid) begin
			if (cfg_index == REG_MAX_PAYLOAD) begin
				max_payload_q <= cfg_data[LEN_W-1:0];
			end else if (cfg_index == REG_TIMEOUT_TICKS) begin
				timeout_ticks_q <= cfg_data[TICK_W-1:0];
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			in_valid_s1 <= 1'b1;
		end else if (advance) begin
			in_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1  <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

	cfpr_frame_fsm u_fsm (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (in_valid_s1 && advance),
		.item_tick     (cmd_s1),
		.item_byte     (byte_s1),
		.max_payload   (max_payload_q),
		.timeout_ticks (timeout_ticks_q),
		.result        (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= result.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && result.valid) begin
			kind_s2         <= result.kind;
			out_byte_s2     <= result.data;
			frame_length_s2 <= result.length;
		end
	end

	assign m_tvalid = out_valid_s2;
	assign m_tuser  = kind_s2;
	assign m_tdata  = {frame_length_s2, out_byte_s2};

	`CFPR_ASSERT(a_byte_has_no_length,
		(m_tvalid && m_tuser == KIND_BYTE) |-> (m_tdata[OUT_DATA_W-1:BYTE_W] == '0),
		"payload byte transfer carries a nonzero frame length")
	`CFPR_ASSERT(a_verdict_has_no_byte,
		(m_tvalid && m_tuser != KIND_BYTE) |-> (m_tdata[BYTE_W-1:0] == '0),
		"verdict transfer carries a nonzero byte")
	`CFPR_ASSERT(a_stall_only_when_full,
		!s_tready |-> (in_valid_s1 && out_valid_s2 && !m_tready),
		"input stalled while the pipeline could move")
	`CFPR_ASSERT(a_result_needs_item,
		(!$past(in_valid_s1) && !$past(m_tready) && $past(m_tvalid)) |-> m_tvalid,
		"held result dropped without a transfer")
	`CFPR_NEVER(a_kind_in_range,
		m_tvalid && (m_tuser != KIND_BYTE) && (m_tuser != KIND_GOOD) &&
		(m_tuser != KIND_CRC_BAD) && (m_tuser != KIND_STOP_BAD) && (m_tuser != KIND_TIMEOUT),
		"result kind outside the defined codes")

endmodule

@@ hdl/cfpr_frame_fsm.sv @@
// frame state machine: start, length, payload with running crc, crc, stop, tick timeout
// depends on cfpr_pkg
`timescale 1ns / 1ps

module cfpr_frame_fsm (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	input  logic                        item_tick,
	input  logic [cfpr_pkg::BYTE_W-1:0] item_byte,
	input  logic [cfpr_pkg::LEN_W-1:0]  max_payload,
	input  logic [cfpr_pkg::TICK_W-1:0] timeout_ticks,
	output cfpr_pkg::cfpr_result_t      result
);
	import cfpr_pkg::*;

	frame_state_t      state_q, state_d;
	logic [TICK_W-1:0] ticks_left_q, ticks_left_d;
	logic [LEN_W-1:0]  payload_length_q, payload_length_d;
	logic [LEN_W-1:0]  bytes_received_q, bytes_received_d;
	logic [CRC_W-1:0]  running_crc_q, running_crc_d;
	logic [CRC_W-1:0]  received_crc_q, received_crc_d;

	logic [LEN_W-1:0] len_full;
	logic [LEN_W-1:0] count_next;
	logic             len_ok;
	logic             frame_open;

	assign len_full   = payload_length_q | {{(LEN_W-BYTE_W){1'b0}}, item_byte};
	assign len_ok     = (len_full != '0) && (len_full <= max_payload);
	assign count_next = bytes_received_q + LEN_W'(1);
	assign frame_open = (state_q == ST_PAYLOAD) || (state_q == ST_CRC_HI) ||
		(state_q == ST_CRC_LO) || (state_q == ST_STOP);

	// next state
	always_comb begin
		state_d          = state_q;
		ticks_left_d     = ticks_left_q;
		payload_length_d = payload_length_q;
		bytes_received_d = bytes_received_q;
		running_crc_d    = running_crc_q;
		received_crc_d   = received_crc_q;
		if (item_valid) begin
			if (item_tick) begin
				if (ticks_left_q != '0) begin
					ticks_left_d = ticks_left_q - TICK_W'(1);
				end else begin
					state_d = ST_IDLE;
				end
			end else begin
				unique case (state_q)
					ST_IDLE: begin
						if (item_byte == START_SHORT || item_byte == START_LONG) begin
							state_d          = (item_byte == START_SHORT) ? ST_LEN_LO : ST_LEN_HI;
							ticks_left_d     = timeout_ticks;
							bytes_received_d = '0;
							payload_length_d = '0;
							running_crc_d    = '0;
						end
					end
					ST_LEN_HI: begin
						payload_length_d = {item_byte, {(LEN_W-BYTE_W){1'b0}}};
						state_d          = ST_LEN_LO;
						ticks_left_d     = timeout_ticks;
					end
					ST_LEN_LO: begin
						payload_length_d = len_full;
						if (len_ok) begin
							state_d      = ST_PAYLOAD;
							ticks_left_d = timeout_ticks;
						end else begin
							state_d = ST_IDLE;
						end
					end
					ST_PAYLOAD: begin
						running_crc_d    = crc16_byte(running_crc_q, item_byte);
						bytes_received_d = count_next;
						if (count_next == payload_length_q) begin
							state_d = ST_CRC_HI;
						end
						ticks_left_d = timeout_ticks;
					end
					ST_CRC_HI: begin
						received_crc_d = {item_byte, received_crc_q[BYTE_W-1:0]};
						state_d        = ST_CRC_LO;
						ticks_left_d   = timeout_ticks;
					end
					ST_CRC_LO: begin
						received_crc_d = {received_crc_q[CRC_W-1:BYTE_W], item_byte};
						state_d        = ST_STOP;
						ticks_left_d   = timeout_ticks;
					end
					ST_STOP: begin
						state_d = ST_IDLE;
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
		end
	end

	// result
	always_comb begin
		result = '{valid: 1'b0, kind: KIND_BYTE, data: '0, length: '0};
		if (item_valid) begin
			if (item_tick) begin
				if (ticks_left_q == '0 && frame_open) begin
					result.valid  = 1'b1;
					result.kind   = KIND_TIMEOUT;
					result.length = payload_length_q;
				end
			end else if (state_q == ST_PAYLOAD) begin
				result.valid = 1'b1;
				result.kind  = KIND_BYTE;
				result.data  = item_byte;
			end else if (state_q == ST_STOP) begin
				result.valid  = 1'b1;
				result.length = payload_length_q;
				if (item_byte != STOP_BYTE) begin
					result.kind = KIND_STOP_BAD;
				end else if (received_crc_q == running_crc_q) begin
					result.kind = KIND_GOOD;
				end else begin
					result.kind = KIND_CRC_BAD;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			ticks_left_q     <= '0;
			payload_length_q <= '0;
			bytes_received_q <= '0;
			running_crc_q    <= '0;
			received_crc_q   <= '0;
		end else begin
			state_q          <= state_d;
			ticks_left_q     <= ticks_left_d;
			payload_length_q <= payload_length_d;
			bytes_received_q <= bytes_received_d;
			running_crc_q    <= running_crc_d;
			received_crc_q   <= received_crc_d;
		end
	end

endmodule
